### rtl/gfst_pkg.sv
// ----------------------------------------------------------------------------
// gfst_pkg
// Shared types and constants of the geofence speed trigger table.
// ----------------------------------------------------------------------------
package gfst_pkg;

  localparam int MAX_ZONES    = 16;
  localparam int IDX_W        = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CNT_W        = $clog2(MAX_ZONES + 1);
  localparam int ZONE_INDEX_W = 4;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_ENTERED = 2'd1,
    KIND_LEFT    = 2'd2,
    KIND_FULL    = 2'd3
  } event_kind_e;

  // controller to datapath
  typedef struct packed {
    logic             capture;      // item accepted this cycle
    logic             add_push;     // send the add result when the output frees
    logic             issue_valid;  // scan slot enters the pipeline
    logic [IDX_W-1:0] issue_idx;
    logic             issue_flush;  // end-of-scan marker
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] zone_count;
    logic             adv;          // pipeline and output may move this cycle
    logic             pipe_busy;
  } dp_status_t;

endpackage

### rtl/gfst_if.sv
// ----------------------------------------------------------------------------
// gfst_in_if / gfst_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface gfst_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [30:0] zone_radius;
  logic signed [15:0] speed_low;
  logic signed [15:0] speed_high;
  logic signed [15:0] speed_now;

  modport source (
    output valid, op, pos_x, pos_y, zone_radius, speed_low, speed_high, speed_now,
    input  ready
  );
  modport sink (
    input  valid, op, pos_x, pos_y, zone_radius, speed_low, speed_high, speed_now,
    output ready
  );
endinterface

interface gfst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [3:0] zone_index;
  logic       last;

  modport source (
    output valid, event_kind, zone_index, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, zone_index, last,
    output ready
  );
endinterface

### rtl/gfst_ctrl.sv
// ----------------------------------------------------------------------------
// gfst_ctrl
// Sequencer: takes items, walks a check one zone per unstalled cycle, drains.
// ----------------------------------------------------------------------------
module gfst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  output logic                  in_ready_o,
  input  gfst_pkg::dp_status_t  status_i,
  output gfst_pkg::ctrl_cmd_t   cmd_o
);
  import gfst_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ADD   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    scan_d            = scan_q;
    cmd_o.capture     = accept;
    cmd_o.add_push    = 1'b0;
    cmd_o.issue_valid = 1'b0;
    cmd_o.issue_idx   = scan_q[IDX_W-1:0];
    cmd_o.issue_flush = (scan_q == status_i.zone_count);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_d  = '0;
          state_d = (in_op_i == OP_ADD) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        cmd_o.add_push = 1'b1;
        if (status_i.adv) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.issue_valid = 1'b1;
        if (status_i.adv) begin
          if (cmd_o.issue_flush) state_d = ST_DRAIN;
          else scan_d = scan_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

endmodule

### rtl/gfst_dp.sv
// ----------------------------------------------------------------------------
// gfst_dp
// Zone store, test pipeline, edge flags and result registers.
// ----------------------------------------------------------------------------
module gfst_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gfst_pkg::ctrl_cmd_t  cmd_i,
  input  logic                 in_op_i,
  input  logic signed [31:0]   in_pos_x_i,
  input  logic signed [31:0]   in_pos_y_i,
  input  logic        [30:0]   in_zone_radius_i,
  input  logic signed [15:0]   in_speed_low_i,
  input  logic signed [15:0]   in_speed_high_i,
  input  logic signed [15:0]   in_speed_now_i,
  output gfst_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_event_kind_o,
  output logic [3:0]           out_zone_index_o,
  output logic                 out_last_o
);
  import gfst_pkg::*;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [30:0] radius;
    logic signed [15:0] spd_high;
    logic signed [15:0] spd_low;
  } zone_t;

  zone_t            store_mem [MAX_ZONES];
  zone_t            rd_q;

  logic [CNT_W-1:0] count_q;
  logic [MAX_ZONES-1:0] flags_q;
  logic             full;
  logic             adv;

  // captured check item
  logic signed [31:0] px_q, py_q;
  logic signed [15:0] spd_q;

  // add result
  event_kind_e      add_kind_q;
  logic [IDX_W-1:0] add_idx_q;

  // stage 1: store data registered
  logic             s1_v_q, s1_flush_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic signed [32:0] dx_s, dy_s;
  logic [31:0]      dx_mag, dy_mag;
  logic             spd_ok;

  // stage 2: magnitudes
  logic             s2_v_q, s2_flush_q, s2_spd_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic [31:0]      dx_q, dy_q;
  logic [30:0]      r_q;

  // stage 3: squares
  logic             s3_v_q, s3_flush_q, s3_spd_q;
  logic [IDX_W-1:0] s3_idx_q;
  logic [63:0]      a_q, b_q;
  logic [61:0]      r2_q;
  logic [64:0]      dist2;
  logic             hit, edge_seen;
  event_kind_e      s3_kind;

  // one-deep hold so the final result of a scan can carry last
  logic             pend_v_q;
  event_kind_e      pend_kind_q;
  logic [IDX_W-1:0] pend_idx_q;

  logic             out_v_q;
  event_kind_e      out_kind_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_last_q;

  assign full = (count_q == CNT_W'(MAX_ZONES));
  assign adv  = !out_v_q || out_ready_i;

  assign status_o.zone_count = count_q;
  assign status_o.adv        = adv;
  assign status_o.pipe_busy  = s1_v_q || s2_v_q || s3_v_q;

  // store: written on an accepted add if not full, one zone read per scan slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_op_i == OP_ADD && !full) begin
      store_mem[count_q[IDX_W-1:0]] <= '{cx: in_pos_x_i, cy: in_pos_y_i,
                                         radius: in_zone_radius_i,
                                         spd_high: in_speed_high_i,
                                         spd_low: in_speed_low_i};
    end
    if (adv && cmd_i.issue_valid && !cmd_i.issue_flush) begin
      rd_q <= store_mem[cmd_i.issue_idx];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q       <= in_pos_x_i;
      py_q       <= in_pos_y_i;
      spd_q      <= in_speed_now_i;
      add_kind_q <= full ? KIND_FULL : KIND_ADDED;
      add_idx_q  <= full ? '0 : count_q[IDX_W-1:0];
    end
  end

  // stage 1 arithmetic
  always_comb begin
    dx_s   = {px_q[31], px_q} - {rd_q.cx[31], rd_q.cx};
    dy_s   = {py_q[31], py_q} - {rd_q.cy[31], rd_q.cy};
    dx_mag = dx_s[32] ? 32'(-dx_s) : dx_s[31:0];
    dy_mag = dy_s[32] ? 32'(-dy_s) : dy_s[31:0];
    spd_ok = (rd_q.spd_low <= spd_q) && (spd_q <= rd_q.spd_high);
  end

  // stage 3 compare and edge detection
  always_comb begin
    dist2     = {1'b0, a_q} + {1'b0, b_q};
    hit       = (dist2 < {3'b000, r2_q}) && s3_spd_q;
    edge_seen = (hit != flags_q[s3_idx_q]);
    s3_kind   = hit ? KIND_ENTERED : KIND_LEFT;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_flush_q <= cmd_i.issue_flush;
      s1_idx_q   <= cmd_i.issue_idx;
      s2_flush_q <= s1_flush_q;
      s2_idx_q   <= s1_idx_q;
      s2_spd_q   <= spd_ok;
      dx_q       <= dx_mag;
      dy_q       <= dy_mag;
      r_q        <= rd_q.radius;
      s3_flush_q <= s2_flush_q;
      s3_idx_q   <= s2_idx_q;
      s3_spd_q   <= s2_spd_q;
      a_q        <= dx_q * dx_q;
      b_q        <= dy_q * dy_q;
      r2_q       <= r_q * r_q;
    end
  end

  // pending and output payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (cmd_i.add_push) begin
        out_kind_q <= add_kind_q;
        out_idx_q  <= add_idx_q;
        out_last_q <= 1'b1;
      end else if (s3_v_q && (s3_flush_q || edge_seen)) begin
        out_kind_q <= pend_kind_q;
        out_idx_q  <= pend_idx_q;
        out_last_q <= s3_flush_q;
      end
      if (s3_v_q && !s3_flush_q && edge_seen) begin
        pend_kind_q <= s3_kind;
        pend_idx_q  <= s3_idx_q;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      flags_q  <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.capture && in_op_i == OP_ADD && !full) begin
        count_q                     <= count_q + CNT_W'(1);
        flags_q[count_q[IDX_W-1:0]] <= 1'b0;
      end
      if (out_ready_i) out_v_q <= 1'b0;
      if (adv) begin
        s1_v_q <= cmd_i.issue_valid;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
        if (cmd_i.add_push) begin
          out_v_q <= 1'b1;
        end else if (s3_v_q && s3_flush_q) begin
          if (pend_v_q) out_v_q <= 1'b1;
          pend_v_q <= 1'b0;
        end else if (s3_v_q && edge_seen) begin
          if (pend_v_q) out_v_q <= 1'b1;
          pend_v_q           <= 1'b1;
          flags_q[s3_idx_q]  <= hit;
        end
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign out_event_kind_o = out_kind_q;
  assign out_zone_index_o = ZONE_INDEX_W'(out_idx_q);
  assign out_last_o       = out_last_q;

endmodule

### rtl/geofence_speed_trigger_table_top.sv
// ----------------------------------------------------------------------------
// geofence_speed_trigger_table_top
// Table of circular trigger zones with speed windows and enter/leave events.
// ----------------------------------------------------------------------------
// An add item stores a zone (center, radius, inclusive speed window) and
// returns one result: the zone's index, or "table full" with index 0. A check
// item (position and speed) tests every stored zone in index order against
// dx*dx + dy*dy < r*r and low <= speed <= high, computed exactly, and returns
// one result per zone whose inside flag changes, entered or left, with last
// set on the final one; a check that changes nothing returns no result.
// An add's result is registered at acceptance and then moved into the output
// register. A check walks the zone store, which has a single read port, one
// zone per cycle while the output does not stall, through a pipeline (store
// read, difference, squares, compare). A new item is taken once the previous
// one has fully passed the pipeline; its last result may still sit in the
// output register. Output stalls freeze the whole pipeline.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module geofence_speed_trigger_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfst_in_if.sink     in_i,
  gfst_out_if.source  out_o
);
  import gfst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  // sequencer: accepts items and walks the table
  gfst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, test pipeline and result registers
  gfst_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .in_op_i          (in_i.op),
    .in_pos_x_i       (in_i.pos_x),
    .in_pos_y_i       (in_i.pos_y),
    .in_zone_radius_i (in_i.zone_radius),
    .in_speed_low_i   (in_i.speed_low),
    .in_speed_high_i  (in_i.speed_high),
    .in_speed_now_i   (in_i.speed_now),
    .status_o         (status),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_event_kind_o (out_o.event_kind),
    .out_zone_index_o (out_o.zone_index),
    .out_last_o       (out_o.last)
  );

endmodule
